// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the heap queue.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define HPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define HPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks during reset.
`define HPQ_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
// No dependencies; used by the interfaces, the core modules and the checker.
package hpq_pkg;

  localparam int KEY_W              = 16;
  localparam int TAG_W              = 16;
  localparam int STATUS_W           = 2;
  localparam int OCC_W              = 7;
  localparam int CAP_W              = 7;
  localparam int HEAP_DEPTH_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXTRACTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Datapath step commands issued by the controller
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_NONE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LOAD    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DECODE  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_UP_CMP  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_UP_FIN  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DN_TOP  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DN_LAST = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DN_L    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DN_R    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DN_CMP  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_RESULT  = 4'd10;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_ext;    // latched operation is an extract
    logic full;      // insert would be refused
    logic empty;     // no entries held
    logic up_swap;   // new key beats the parent just read
    logic par_zero;  // parent of the current hole is the root
    logic l_out;     // left child lies beyond the heap
    logic r_out;     // right child lies beyond the heap
    logic l_wins;    // left child beats the moving entry
    logic r_wins;    // right child beats the best so far
    logic best_l;    // best so far is the left child
  } dp_status_t;

endpackage

// File: rtl/core/hpq_if.sv
// Channel interfaces of the heap queue: request, result and configuration.
// Depends on hpq_pkg.
interface hpq_in_if;
  import hpq_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] priority_key;
  logic [TAG_W-1:0] payload_tag;
  modport source (output valid, operation, priority_key, payload_tag, input ready);
  modport sink   (input valid, operation, priority_key, payload_tag, output ready);
endinterface

interface hpq_out_if;
  import hpq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    result_key;
  logic [TAG_W-1:0]    result_tag;
  logic [OCC_W-1:0]    occupancy;
  modport source (output valid, status, result_key, result_tag, occupancy, input ready);
  modport sink   (input valid, status, result_key, result_tag, occupancy, output ready);
endinterface

interface hpq_cfg_if;
  import hpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_limit;
  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// File: rtl/core/hpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/hpq_ctrl.sv
// Controller state machine of the heap queue: sequences the sift steps.
// Depends on hpq_pkg; drives hpq_dp through cmd_t and reads dp_status_t.
module hpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hpq_pkg::cmd_t      cmd,
  input  hpq_pkg::dp_status_t st
);
  import hpq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_UP_FIN  = 4'd3;
  localparam logic [3:0] S_DN_TOP  = 4'd4;
  localparam logic [3:0] S_DN_LAST = 4'd5;
  localparam logic [3:0] S_DN_L    = 4'd6;
  localparam logic [3:0] S_DN_R    = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.step      = STEP_NONE;
    in_ready      = (state_r == S_IDLE);
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step  = STEP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.step = STEP_DECODE;
        priority if (st.is_ext) begin
          state_nxt = st.empty ? S_RESP : S_DN_TOP;
        end else if (st.full) begin
          state_nxt = S_RESP;
        end else if (st.empty) begin
          state_nxt = S_UP_FIN;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.step = STEP_UP_CMP;
        priority if (!st.up_swap) begin
          state_nxt = S_RESP;
        end else if (st.par_zero) begin
          state_nxt = S_UP_FIN;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_FIN: begin
        cmd.step  = STEP_UP_FIN;
        state_nxt = S_RESP;
      end
      S_DN_TOP: begin
        cmd.step  = STEP_DN_TOP;
        state_nxt = S_DN_LAST;
      end
      S_DN_LAST: begin
        cmd.step  = STEP_DN_LAST;
        state_nxt = S_DN_L;
      end
      S_DN_L: begin
        cmd.step  = STEP_DN_L;
        state_nxt = st.l_out ? S_RESP : S_DN_R;
      end
      S_DN_R: begin
        cmd.step = STEP_DN_R;
        priority if (!st.r_out) begin
          state_nxt = S_DN_CMP;
        end else if (st.l_wins) begin
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DN_CMP: begin
        cmd.step  = STEP_DN_CMP;
        state_nxt = (st.r_wins || st.best_l) ? S_DN_L : S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.step      = STEP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/hpq_dp.sv
// Datapath of the heap queue: heap RAM, hole position, entry registers, result register.
// Depends on hpq_pkg and hpq_ram; steered by hpq_ctrl through cmd_t.
module hpq_dp #(
  parameter int HEAP_DEPTH = hpq_pkg::HEAP_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hpq_pkg::cmd_t                cmd,
  output hpq_pkg::dp_status_t          st,
  input  logic                         cfg_wr,
  input  logic [hpq_pkg::CAP_W-1:0]    cfg_data,
  input  logic                         in_operation,
  input  logic [hpq_pkg::KEY_W-1:0]    in_key,
  input  logic [hpq_pkg::TAG_W-1:0]    in_tag,
  output logic [hpq_pkg::STATUS_W-1:0] res_status,
  output logic [hpq_pkg::KEY_W-1:0]    res_key,
  output logic [hpq_pkg::TAG_W-1:0]    res_tag,
  output logic [hpq_pkg::OCC_W-1:0]    res_occupancy
);
  import hpq_pkg::*;

  localparam int AW  = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);
  localparam int CHW = AW + 1;
  localparam int LW  = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                op_r, op_nxt;
  entry_t              new_r, new_nxt;
  entry_t              top_r, top_nxt;
  entry_t              mov_r, mov_nxt;
  entry_t              best_r, best_nxt;
  logic                best_l_r, best_l_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [OCC_W-1:0]    res_occ_r, res_occ_nxt;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  entry_t             mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t             rd_entry;

  logic [AW-1:0]  pos_m1, par_pos, par_m1, par_par;
  logic [CW-1:0]  count_m1;
  logic [AW-1:0]  par_cnt;
  logic [CHW-1:0] child_l, child_r, n_ext;
  logic           full, empty;

  hpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_entry = entry_t'(mem_rdata);

  // Heap index arithmetic: parent is (i-1)/2, children 2i+1 and 2i+2
  assign pos_m1   = pos_r - AW'(1);
  assign par_pos  = pos_m1 >> 1;
  assign par_m1   = par_pos - AW'(1);
  assign par_par  = par_m1 >> 1;
  assign count_m1 = count_r - CW'(1);
  assign par_cnt  = AW'(count_m1 >> 1);
  assign child_l  = {pos_r, 1'b1};
  assign child_r  = {pos_r, 1'b0} + CHW'(2);
  assign n_ext    = CHW'(n_r);

  assign full  = (LW'(count_r) >= LW'(cap_r)) || (count_r == CW'(HEAP_DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    st.is_ext   = (op_r == OP_EXTRACT);
    st.full     = full;
    st.empty    = empty;
    st.up_swap  = new_r.key > rd_entry.key;
    st.par_zero = (par_pos == '0);
    st.l_out    = child_l >= n_ext;
    st.r_out    = child_r >= n_ext;
    st.l_wins   = rd_entry.key > mov_r.key;
    st.r_wins   = rd_entry.key > best_r.key;
    st.best_l   = best_l_r;
  end

  always_comb begin
    cap_nxt        = cfg_wr ? cfg_data : cap_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    new_nxt        = new_r;
    top_nxt        = top_r;
    mov_nxt        = mov_r;
    best_nxt       = best_r;
    best_l_nxt     = best_l_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    status_nxt     = status_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_occ_nxt    = res_occ_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = mov_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    unique case (cmd.step)
      STEP_NONE: begin
      end
      STEP_LOAD: begin
        op_nxt  = in_operation;
        new_nxt = '{key: in_key, tag: in_tag};
      end
      STEP_DECODE: begin
        if (op_r == OP_INSERT) begin
          if (full) begin
            status_nxt = STATUS_FULL;
          end else begin
            status_nxt = STATUS_INSERTED;
            pos_nxt    = AW'(count_r);
            count_nxt  = count_r + CW'(1);
            mem_re     = 1'b1;
            mem_raddr  = par_cnt;
          end
        end else begin
          if (empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            status_nxt = STATUS_EXTRACTED;
            n_nxt      = count_m1;
            count_nxt  = count_m1;
            mem_re     = 1'b1;
            mem_raddr  = '0;
          end
        end
      end
      STEP_UP_CMP: begin
        mem_we = 1'b1;
        if (st.up_swap) begin
          // move the parent down into the hole and climb
          mem_wdata = rd_entry;
          pos_nxt   = par_pos;
          mem_re    = 1'b1;
          mem_raddr = par_par;
        end else begin
          mem_wdata = new_r;
        end
      end
      STEP_UP_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = new_r;
      end
      STEP_DN_TOP: begin
        top_nxt   = rd_entry;
        mem_re    = 1'b1;
        mem_raddr = AW'(n_r);
      end
      STEP_DN_LAST: begin
        mov_nxt = rd_entry;
        pos_nxt = '0;
      end
      STEP_DN_L: begin
        if (st.l_out) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(child_l);
        end
      end
      STEP_DN_R: begin
        if (st.r_out) begin
          mem_we = 1'b1;
          if (st.l_wins) begin
            mem_wdata = rd_entry;
            pos_nxt   = AW'(child_l);
          end
        end else begin
          best_nxt   = st.l_wins ? rd_entry : mov_r;
          best_l_nxt = st.l_wins;
          mem_re     = 1'b1;
          mem_raddr  = AW'(child_r);
        end
      end
      STEP_DN_CMP: begin
        mem_we = 1'b1;
        priority if (st.r_wins) begin
          mem_wdata = rd_entry;
          pos_nxt   = AW'(child_r);
        end else if (best_l_r) begin
          mem_wdata = best_r;
          pos_nxt   = AW'(child_l);
        end else begin
          mem_wdata = mov_r;
        end
      end
      STEP_RESULT: begin
        res_status_nxt = status_r;
        res_occ_nxt    = OCC_W'(count_r);
        unique case (status_r)
          STATUS_INSERTED: begin
            res_key_nxt = new_r.key;
            res_tag_nxt = new_r.tag;
          end
          STATUS_EXTRACTED: begin
            res_key_nxt = top_r.key;
            res_tag_nxt = top_r.tag;
          end
          default: begin
            res_key_nxt = '0;
            res_tag_nxt = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
    end else begin
      cap_r   <= cap_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    new_r        <= new_nxt;
    top_r        <= top_nxt;
    mov_r        <= mov_nxt;
    best_r       <= best_nxt;
    best_l_r     <= best_l_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    status_r     <= status_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_occ_r    <= res_occ_nxt;
  end

  assign res_status    = res_status_r;
  assign res_key       = res_key_r;
  assign res_tag       = res_tag_r;
  assign res_occupancy = res_occ_r;

endmodule

// File: rtl/core/max_heap_priority_queue.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation, priority_key, payload_tag
// out_ch    out  valid/ready    status, result_key, result_tag, occupancy
// cfg_ch    in   valid/ready    capacity_limit (ready always high)
//
// One request at a time; the heap RAM port (one read, one write per cycle) sets the pace.
// Insert: load and decode, then a compare step for each level climbed, then the result.
// Extract: load and decode, read the top and the last entry, then per level a left read,
// a right read and a compare, ending early when a child lies beyond the heap.
// Refusals skip the sift; a result held in out_ch does not block the next request.
// Reset clears the entry count, the limit (to 64) and the handshake state, not the RAM.
//
// Top level of the heap queue; depends on hpq_pkg, hpq_if, hpq_ctrl and hpq_dp.
module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = hpq_pkg::HEAP_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst_n,
  hpq_in_if.sink    in_ch,
  hpq_out_if.source out_ch,
  hpq_cfg_if.sink   cfg_ch
);
  import hpq_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  assign cfg_ch.ready = 1'b1;

  hpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st)
  );

  hpq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cfg_wr        (cfg_ch.valid),
    .cfg_data      (cfg_ch.capacity_limit),
    .in_operation  (in_ch.operation),
    .in_key        (in_ch.priority_key),
    .in_tag        (in_ch.payload_tag),
    .res_status    (out_ch.status),
    .res_key       (out_ch.result_key),
    .res_tag       (out_ch.result_tag),
    .res_occupancy (out_ch.occupancy)
  );

endmodule

// File: rtl/core/hpq_checker.sv
// Port-level assertions on the heap queue result channel, bound to the top level.
// Depends on hpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hpq_checker #(
  parameter int HEAP_DEPTH = hpq_pkg::HEAP_DEPTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [hpq_pkg::STATUS_W-1:0] status,
  input logic [hpq_pkg::KEY_W-1:0]    result_key,
  input logic [hpq_pkg::TAG_W-1:0]    result_tag,
  input logic [hpq_pkg::OCC_W-1:0]    occupancy
);
  import hpq_pkg::*;

  `HPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(result_key) && $stable(result_tag)
      && $stable(occupancy), "stalled transaction changed")
  `HPQ_ASSERT_IMPL(a_refused_zero,
    out_valid && (status == STATUS_FULL || status == STATUS_EMPTY),
    result_key == '0 && result_tag == '0, "refusal carries nonzero entry")
  `HPQ_ASSERT_IMPL(a_empty_occ, out_valid && status == STATUS_EMPTY, occupancy == '0,
    "empty refusal with entries held")
  `HPQ_ASSERT_IMPL(a_occ_bound, out_valid, 32'(occupancy) <= HEAP_DEPTH,
    "occupancy above heap depth")
  `HPQ_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid, "result valid after reset")

endmodule

bind max_heap_priority_queue hpq_checker #(
  .HEAP_DEPTH (HEAP_DEPTH)
) u_hpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .result_key (out_ch.result_key),
  .result_tag (out_ch.result_tag),
  .occupancy  (out_ch.occupancy)
);

// File: tb/tb_top.sv
// Self-checking bench for max_heap_priority_queue: directed and random insert/extract
// traffic with random stalls, checked by a behavioral max-heap in a scoreboard class.
// Depends on hpq_pkg, the hpq_if channel interfaces and the RTL top level.
module tb_top;
  import hpq_pkg::*;

  localparam int DEPTH         = HEAP_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 127;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [TAG_W-1:0]    tag;
    logic [OCC_W-1:0]    occ;
  } heap_result_t;

  // Behavioral heap plus the queue of results it predicts.
  class heap_scoreboard;
    entry_t       heap_mem[DEPTH];
    int unsigned  entry_count;
    int unsigned  cap_limit;
    heap_result_t expected_q[$];
    int unsigned  error_count;
    int unsigned  status_seen[4];

    function new();
      entry_count = 0;
      cap_limit   = CAP_RESET;
      error_count = 0;
      foreach (heap_mem[i]) heap_mem[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_limit(logic [CAP_W-1:0] value);
      cap_limit = value;
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      entry_t t;
      t = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
    endfunction

    function void sift_up(int unsigned start);
      int unsigned pos;
      int unsigned parent;
      pos = start;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (heap_mem[pos].key <= heap_mem[parent].key) break;
        swap_entries(pos, parent);
        pos = parent;
      end
    endfunction

    // Left child first; the right one wins only when strictly greater.
    function void sift_down(int unsigned n);
      int unsigned pos;
      int unsigned l;
      int unsigned r;
      int unsigned best;
      pos = 0;
      forever begin
        l = 2 * pos + 1;
        r = l + 1;
        best = pos;
        if (l < n && heap_mem[l].key > heap_mem[best].key) best = l;
        if (r < n && heap_mem[r].key > heap_mem[best].key) best = r;
        if (best == pos) break;
        swap_entries(pos, best);
        pos = best;
      end
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      heap_result_t res;
      entry_t       top;
      int unsigned  lim;
      lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
      res = '0;
      if (op == OP_INSERT) begin
        if (entry_count >= lim) begin
          res.status = STATUS_FULL;
        end else begin
          heap_mem[entry_count].key = key;
          heap_mem[entry_count].tag = tag;
          sift_up(entry_count);
          entry_count++;
          res.status = STATUS_INSERTED;
          res.key    = key;
          res.tag    = tag;
        end
      end else begin
        if (entry_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          top = heap_mem[0];
          entry_count--;
          heap_mem[0] = heap_mem[entry_count];
          heap_mem[entry_count] = top;
          sift_down(entry_count);
          res.status = STATUS_EXTRACTED;
          res.key    = top.key;
          res.tag    = top.tag;
        end
      end
      res.occ = OCC_W'(entry_count);
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual status %0d key %0d",
                   $time, got.status, got.key);
        return;
      end
      want = expected_q.pop_front();
      status_seen[got.status]++;
      compare_field("status", want.status, got.status);
      compare_field("result_key", want.key, got.key);
      compare_field("result_tag", want.tag, got.tag);
      compare_field("occupancy", want.occ, got.occ);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  bit          quiet_tail = 1'b0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 25;
  int unsigned recv_hold = 0;
  int unsigned limit_writes = 0;

  heap_scoreboard sb = new();

  hpq_in_if  in_ch();
  hpq_out_if out_ch();
  hpq_cfg_if cfg_ch();

  max_heap_priority_queue #(.HEAP_DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
      $display("max_heap_priority_queue regression: fail");
      $finish;
    end
  end

  // Observe every transaction on the three channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_limit(cfg_ch.capacity_limit);
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.operation, in_ch.priority_key, in_ch.payload_tag);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(heap_result_t'{out_ch.status, out_ch.result_key,
                                       out_ch.result_tag, out_ch.occupancy});
    end
  end

  // Result side: drop ready at random, in bursts of random length.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold--;
      out_ch.ready = 1'b0;
    end else if (!quiet_tail && recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_hold = $urandom_range(1, 8) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag);
    int unsigned gap;
    @(negedge clk);
    if (!quiet_tail && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.operation    = op;
    in_ch.priority_key = key;
    in_ch.payload_tag  = tag;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the request channel until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input int unsigned value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid          = 1'b1;
    cfg_ch.capacity_limit = CAP_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    limit_writes++;
  endtask

  // Crowd keys into a narrow band often so that ties are common.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1:    return KEY_W'($urandom_range(0, 7));
      2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return KEY_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase_limit[RANDOM_PHASES];
    int unsigned insert_pct[RANDOM_PHASES];
    int unsigned send_pct_tbl[RANDOM_PHASES];
    int unsigned recv_pct_tbl[RANDOM_PHASES];
    logic op;

    phase_limit           = '{64, 64, 17, 1, 63, 2, 64, 64, 40, 64, 8, 64};
    insert_pct            = '{75, 70, 50, 60, 50, 50, 55, 30, 50, 80, 40, 25};
    send_pct_tbl          = '{25, 0, 40, 25, 10, 50, 25, 0, 30, 25, 40, 0};
    recv_pct_tbl          = '{25, 40, 0, 25, 50, 10, 25, 30, 0, 25, 40, 0};
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_INSERT;
    in_ch.priority_key    = '0;
    in_ch.payload_tag     = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.capacity_limit = CAP_RESET;
    phase_limit[6]        = $urandom_range(1, 64);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty extract, key extremes, equal-key ordering.
    send_request(OP_EXTRACT, '0, '0);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_INSERT, 16'd5, 16'hAAAA);
    send_request(OP_INSERT, 16'd5, 16'h5555);
    send_request(OP_INSERT, 16'd5, 16'h1234);
    repeat (6) send_request(OP_EXTRACT, '1, '1);

    // Smallest limit: second insert refused.
    write_limit(1);
    send_request(OP_INSERT, 16'd7, 16'd1);
    send_request(OP_INSERT, 16'd8, 16'd2);
    send_request(OP_EXTRACT, '0, '0);
    send_request(OP_EXTRACT, '0, '0);

    // Lower the limit below the occupancy already held.
    write_limit(64);
    send_request(OP_INSERT, 16'd100, 16'h0F0F);
    send_request(OP_INSERT, 16'd200, 16'hF0F0);
    send_request(OP_INSERT, 16'd300, 16'h00FF);
    write_limit(2);
    send_request(OP_INSERT, 16'd400, 16'd9);
    send_request(OP_EXTRACT, '0, '0);
    send_request(OP_INSERT, 16'd500, 16'd10);
    send_request(OP_EXTRACT, '0, '0);
    send_request(OP_INSERT, 16'd600, 16'd11);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      send_idle_pct = send_pct_tbl[p];
      recv_idle_pct = recv_pct_tbl[p];
      if (p == RANDOM_PHASES - 1) quiet_tail = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = ($urandom_range(0, 99) < insert_pct[p]) ? OP_INSERT : OP_EXTRACT;
        send_request(op, pick_key(), TAG_W'($urandom()));
        // Let the pipeline empty once mid-run with traffic still pending.
        if (p == 3 && i == PHASE_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);

    $display("covered %0d inserts, %0d extracts, %0d refused full, %0d refused empty",
             sb.status_seen[STATUS_INSERTED], sb.status_seen[STATUS_EXTRACTED],
             sb.status_seen[STATUS_FULL], sb.status_seen[STATUS_EMPTY]);
    $display("across %0d capacity writes from 1 to 64 with random stalls on both sides",
             limit_writes);
    if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
      $display("max_heap_priority_queue regression: pass");
    end else begin
      $display("max_heap_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
